>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the planner rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mffp_pkg.sv
// ----------------------------------------------------------------------------
// mffp_pkg
// types, constants and helpers for the flood fill planner
// ----------------------------------------------------------------------------
package mffp_pkg;

  localparam int unsigned GRID_SIDE = 16;
  localparam int unsigned CELLS     = 256;

  typedef logic [7:0] cell_t;
  typedef logic [7:0] dist_t;
  typedef logic [8:0] qptr_t;

  localparam dist_t UNREACHED = 8'd255;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  localparam logic [2:0] MV_IDLE     = 3'd0;
  localparam logic [2:0] MV_STRAIGHT = 3'd1;
  localparam logic [2:0] MV_RIGHT    = 3'd2;
  localparam logic [2:0] MV_LEFT     = 3'd3;
  localparam logic [2:0] MV_AROUND   = 3'd4;

  typedef struct packed {
    cell_t      wall_raddr;
    logic       wall_we;
    cell_t      wall_waddr;
    logic [3:0] wall_wdata;
    cell_t      dist_raddr;
    logic       dist_we;
    cell_t      dist_waddr;
    dist_t      dist_wdata;
  } map_req_t;

  function automatic logic in_grid(logic [4:0] r, logic [4:0] c);
    return (32'(r) < GRID_SIDE) && (32'(c) < GRID_SIDE);
  endfunction

  function automatic logic [4:0] nbr_row(logic [3:0] r, logic [1:0] side);
    logic [4:0] res;
    res = {1'b0, r};
    if (side == SIDE_N) res = {1'b0, r} - 5'd1;
    else if (side == SIDE_S) res = {1'b0, r} + 5'd1;
    return res;
  endfunction

  function automatic logic [4:0] nbr_col(logic [3:0] c, logic [1:0] side);
    logic [4:0] res;
    res = {1'b0, c};
    if (side == SIDE_W) res = {1'b0, c} - 5'd1;
    else if (side == SIDE_E) res = {1'b0, c} + 5'd1;
    return res;
  endfunction

  // visiting order: open cell west, east, south, north; walled north, south, east, west
  function automatic logic [1:0] order_side(logic [3:0] w, logic [1:0] k);
    logic [1:0] s;
    s = SIDE_N;
    if (w == 4'd0) begin
      case (k)
        2'd0: s = SIDE_W;
        2'd1: s = SIDE_E;
        2'd2: s = SIDE_S;
        default: s = SIDE_N;
      endcase
    end else begin
      case (k)
        2'd0: s = SIDE_N;
        2'd1: s = SIDE_S;
        2'd2: s = SIDE_E;
        default: s = SIDE_W;
      endcase
    end
    return s;
  endfunction

  function automatic logic [3:0] wall_reset(logic [3:0] r, logic [3:0] c);
    logic [3:0] w;
    w = 4'd0;
    if (r == 4'd0) w[SIDE_N] = 1'b1;
    if (c == 4'd0) w[SIDE_W] = 1'b1;
    if (32'(r) == GRID_SIDE - 1) w[SIDE_S] = 1'b1;
    if (32'(c) == GRID_SIDE - 1) w[SIDE_E] = 1'b1;
    if (32'(r) == GRID_SIDE - 1 && c == 4'd0) w[SIDE_E] = 1'b1;
    if (32'(r) == GRID_SIDE - 1 && c == 4'd1) w[SIDE_W] = 1'b1;
    return w;
  endfunction

endpackage

>>> rtl/core/mffp_map.sv
// ----------------------------------------------------------------------------
// mffp_map
// wall map and distance map memories, one read and one write port each
// ----------------------------------------------------------------------------
module mffp_map
  import mffp_pkg::*;
(
  input  logic       clk_i,
  input  map_req_t   req_i,
  output logic [3:0] wall_rdata_o,
  output dist_t      dist_rdata_o
);

  logic [3:0] wall_mem [CELLS];
  dist_t      dist_mem [CELLS];
  logic [3:0] wall_rdata_q;
  dist_t      dist_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wall_we) begin
      wall_mem[req_i.wall_waddr] <= req_i.wall_wdata;
    end
    wall_rdata_q <= wall_mem[req_i.wall_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.dist_we) begin
      dist_mem[req_i.dist_waddr] <= req_i.dist_wdata;
    end
    dist_rdata_q <= dist_mem[req_i.dist_raddr];
  end

  assign wall_rdata_o = wall_rdata_q;
  assign dist_rdata_o = dist_rdata_q;

endmodule

>>> rtl/core/mffp_queue.sv
// ----------------------------------------------------------------------------
// mffp_queue
// breadth-first cell queue with head and tail pointers
// ----------------------------------------------------------------------------
module mffp_queue
  import mffp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clear_i,
  input  logic  push_i,
  input  cell_t push_data_i,
  input  logic  pop_i,
  output cell_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

`include "assert_macros.svh"

  cell_t q_mem [CELLS];
  cell_t rdata_q;
  qptr_t head_q, head_d;
  qptr_t tail_q, tail_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (clear_i) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (push_i) tail_d = tail_q + qptr_t'(1);
      if (pop_i) head_d = head_q + qptr_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !clear_i) begin
      q_mem[tail_q[7:0]] <= push_data_i;
    end
    rdata_q <= q_mem[head_q[7:0]];
  end

  assign rdata_o = rdata_q;
  assign empty_o = (head_q == tail_q);
  assign full_o  = tail_q[8];

  `ASSERT_ALW(a_head_le_tail, clk_i, head_q <= tail_q, "queue head passed tail")
  `ASSERT_RST(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")

endmodule

>>> rtl/core/maze_flood_fill_planner.sv
// ----------------------------------------------------------------------------
// maze_flood_fill_planner
// wall map upkeep and breadth-first flood replanning for a square maze
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid_i/in_stall_o  kind, cell_row/col, wall_side, pos_row/col, heading
// out       out  out_valid_o/out_stall_i move, next_row/col, pos_distance, at_goal
// cfg       in   apb psel/penable       goal_row @0, goal_col @4
//
// after reset the wall map is initialised for all 256 cells, no request is taken then
// add-wall: read-modify-write on the wall memory in S_AW, S_AW1 and S_AW2, the far side only if in the grid
// replan: a distance sweep over all 256 cells, a seed write of the goal, then for each reached cell
//   the states S_POP, S_CELL_RD, S_CELL and S_NBR, with one distance-memory read per neighbour
// a finished result waits in the output register while the next request is taken
module maze_flood_fill_planner
  import mffp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  cell_row_i,
  input  logic [3:0]  cell_col_i,
  input  logic [1:0]  wall_side_i,
  input  logic [3:0]  pos_row_i,
  input  logic [3:0]  pos_col_i,
  input  logic [1:0]  heading_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  move_o,
  output logic [3:0]  next_row_o,
  output logic [3:0]  next_col_o,
  output logic [7:0]  pos_distance_o,
  output logic        at_goal_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AW, S_AW1, S_AW2, S_SWEEP, S_SEED, S_POP,
    S_CELL_RD, S_CELL, S_NBR, S_POS, S_POSD, S_PNBR, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] cnt_q, cnt_d;
  logic [3:0] goal_row_q, goal_row_d, goal_col_q, goal_col_d;
  cell_t      cell_q, cell_d;
  logic [1:0] side_q, side_d;
  cell_t      pos_q, pos_d;
  logic [1:0] head_q, head_d;
  cell_t      cur_q, cur_d;
  logic [3:0] walls_q, walls_d;
  dist_t      d_q, d_d;
  logic [2:0] k_q, k_d;
  logic       pend_q, pend_d;
  cell_t      pend_addr_q, pend_addr_d;
  dist_t      bd_q, bd_d;
  cell_t      best_q, best_d;
  dist_t      pdist_q, pdist_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] move_q, move_d;
  cell_t      next_q, next_d;
  dist_t      pos_dist_q, pos_dist_d;
  logic       at_goal_q, at_goal_d;

  map_req_t   req;
  logic [3:0] wall_rdata;
  dist_t      dist_rdata;
  logic       q_clear, q_push, q_pop, q_empty, q_full;
  cell_t      q_push_data, q_rdata;

  logic       accept, cfg_we;
  logic [1:0] nside, aw_opp;
  logic [4:0] nr5, nc5, ar5, ac5;
  logic       nvalid, aw_nok;
  cell_t      naddr;
  logic [1:0] dir;
  logic [2:0] mv;

  mffp_map u_map (
    .clk_i        (clk_i),
    .req_i        (req),
    .wall_rdata_o (wall_rdata),
    .dist_rdata_o (dist_rdata)
  );

  mffp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (q_clear),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .rdata_o     (q_rdata),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? {28'd0, goal_col_q} : {28'd0, goal_row_q};

  // neighbour k of the current cell
  assign nside  = order_side(walls_q, k_q[1:0]);
  assign nr5    = nbr_row(cur_q[7:4], nside);
  assign nc5    = nbr_col(cur_q[3:0], nside);
  assign nvalid = !k_q[2] && !walls_q[nside] && in_grid(nr5, nc5);
  assign naddr  = {nr5[3:0], nc5[3:0]};

  // far side of a new wall
  assign ar5    = nbr_row(cell_q[7:4], side_q);
  assign ac5    = nbr_col(cell_q[3:0], side_q);
  assign aw_nok = in_grid(ar5, ac5);
  assign aw_opp = side_q + 2'd2;

  // move relative to heading
  always_comb begin
    if (best_q[3:0] < pos_q[3:0]) dir = SIDE_W;
    else if (best_q[3:0] > pos_q[3:0]) dir = SIDE_E;
    else if (best_q[7:4] < pos_q[7:4]) dir = SIDE_N;
    else dir = SIDE_S;
    if (best_q == pos_q) mv = MV_IDLE;
    else if (dir == head_q) mv = MV_STRAIGHT;
    else if (dir == head_q + 2'd1) mv = MV_RIGHT;
    else if (dir == head_q + 2'd3) mv = MV_LEFT;
    else mv = MV_AROUND;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    goal_row_d  = goal_row_q;
    goal_col_d  = goal_col_q;
    cell_d      = cell_q;
    side_d      = side_q;
    pos_d       = pos_q;
    head_d      = head_q;
    cur_d       = cur_q;
    walls_d     = walls_q;
    d_d         = d_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    bd_d        = bd_q;
    best_d      = best_q;
    pdist_d     = pdist_q;
    move_d      = move_q;
    next_d      = next_q;
    pos_dist_d  = pos_dist_q;
    at_goal_d   = at_goal_q;
    out_valid_d = out_valid_q && out_stall_i;
    req         = '0;
    q_clear     = 1'b0;
    q_push      = 1'b0;
    q_pop       = 1'b0;
    q_push_data = pend_addr_q;

    if (cfg_we && paddr == 3'd0) goal_row_d = pwdata[3:0];
    if (cfg_we && paddr == 3'd4) goal_col_d = pwdata[3:0];

    case (state_q)
      S_INIT: begin
        req.wall_we    = 1'b1;
        req.wall_waddr = cnt_q;
        req.wall_wdata = wall_reset(cnt_q[7:4], cnt_q[3:0]);
        cnt_d          = cnt_q + 8'd1;
        if (cnt_q == 8'hff) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cell_d = {cell_row_i, cell_col_i};
          side_d = wall_side_i;
          pos_d  = {pos_row_i, pos_col_i};
          head_d = heading_i;
          cnt_d  = '0;
          if (kind_i) begin
            q_clear = 1'b1;
            state_d = S_SWEEP;
          end else if (in_grid({1'b0, cell_row_i}, {1'b0, cell_col_i})) begin
            state_d = S_AW;
          end
        end
      end
      S_AW: begin
        req.wall_raddr = cell_q;
        state_d        = S_AW1;
      end
      S_AW1: begin
        req.wall_we    = 1'b1;
        req.wall_waddr = cell_q;
        req.wall_wdata = wall_rdata | (4'd1 << side_q);
        req.wall_raddr = {ar5[3:0], ac5[3:0]};
        state_d        = aw_nok ? S_AW2 : S_IDLE;
      end
      S_AW2: begin
        req.wall_we    = 1'b1;
        req.wall_waddr = {ar5[3:0], ac5[3:0]};
        req.wall_wdata = wall_rdata | (4'd1 << aw_opp);
        state_d        = S_IDLE;
      end
      S_SWEEP: begin
        req.dist_we    = 1'b1;
        req.dist_waddr = cnt_q;
        req.dist_wdata = UNREACHED;
        cnt_d          = cnt_q + 8'd1;
        if (cnt_q == 8'hff) begin
          state_d = in_grid({1'b0, goal_row_q}, {1'b0, goal_col_q}) ? S_SEED : S_POS;
        end
      end
      S_SEED: begin
        req.dist_we    = 1'b1;
        req.dist_waddr = {goal_row_q, goal_col_q};
        req.dist_wdata = '0;
        q_push         = 1'b1;
        q_push_data    = {goal_row_q, goal_col_q};
        state_d        = S_POP;
      end
      S_POP: begin
        state_d = q_empty ? S_POS : S_CELL_RD;
      end
      S_CELL_RD: begin
        cell_d         = q_rdata;
        req.wall_raddr = q_rdata;
        req.dist_raddr = q_rdata;
        state_d        = S_CELL;
      end
      S_CELL: begin
        walls_d = wall_rdata;
        d_d     = (dist_rdata == UNREACHED) ? UNREACHED : dist_rdata + dist_t'(1);
        cur_d   = cell_q;
        k_d     = '0;
        pend_d  = 1'b0;
        state_d = S_NBR;
      end
      S_NBR: begin
        req.dist_raddr = naddr;
        pend_d         = nvalid;
        pend_addr_d    = naddr;
        if (pend_q && dist_rdata == UNREACHED && !q_full) begin
          req.dist_we    = 1'b1;
          req.dist_waddr = pend_addr_q;
          req.dist_wdata = d_q;
          q_push         = 1'b1;
        end
        if (k_q[2]) begin
          q_pop   = 1'b1;
          state_d = S_POP;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      S_POS: begin
        req.wall_raddr = pos_q;
        req.dist_raddr = pos_q;
        best_d         = pos_q;
        pdist_d        = UNREACHED;
        state_d        = in_grid({1'b0, pos_q[7:4]}, {1'b0, pos_q[3:0]}) ? S_POSD : S_DONE;
      end
      S_POSD: begin
        walls_d = wall_rdata;
        pdist_d = dist_rdata;
        bd_d    = dist_rdata;
        cur_d   = pos_q;
        k_d     = '0;
        pend_d  = 1'b0;
        state_d = S_PNBR;
      end
      S_PNBR: begin
        req.dist_raddr = naddr;
        pend_d         = nvalid;
        pend_addr_d    = naddr;
        if (pend_q && dist_rdata < bd_q) begin
          bd_d   = dist_rdata;
          best_d = pend_addr_q;
        end
        if (k_q[2]) state_d = S_DONE;
        else k_d = k_q + 3'd1;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          move_d      = mv;
          next_d      = best_q;
          pos_dist_d  = pdist_q;
          at_goal_d   = (pos_q == {goal_row_q, goal_col_q});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      goal_row_q  <= 4'd7;
      goal_col_q  <= 4'd7;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      goal_row_q  <= goal_row_d;
      goal_col_q  <= goal_col_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q      <= cell_d;
    side_q      <= side_d;
    pos_q       <= pos_d;
    head_q      <= head_d;
    cur_q       <= cur_d;
    walls_q     <= walls_d;
    d_q         <= d_d;
    pend_addr_q <= pend_addr_d;
    bd_q        <= bd_d;
    best_q      <= best_d;
    pdist_q     <= pdist_d;
    move_q      <= move_d;
    next_q      <= next_d;
    pos_dist_q  <= pos_dist_d;
    at_goal_q   <= at_goal_d;
  end

  assign out_valid_o    = out_valid_q;
  assign move_o         = move_q;
  assign next_row_o     = next_q[7:4];
  assign next_col_o     = next_q[3:0];
  assign pos_distance_o = pos_dist_q;
  assign at_goal_o      = at_goal_q;

  `ASSERT_RST(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result without finished replan")

endmodule

>>> bench/tb_maze_flood_fill_planner.sv
// ----------------------------------------------------------------------------
// tb_maze_flood_fill_planner
// self-checking bench for the flood fill planner: directed table, random maze
// building and replans, predicted by a local flood model, random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_maze_flood_fill_planner;
  import mffp_pkg::*;

  localparam int REG_GOAL_ROW = 0;
  localparam int REG_GOAL_COL = 1;
  localparam logic KIND_WALL   = 1'b0;
  localparam logic KIND_REPLAN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [1:0] wall_side;
    logic [3:0] pos_row;
    logic [3:0] pos_col;
    logic [1:0] heading;
  } request_t;

  typedef struct packed {
    logic [2:0] move;
    logic [3:0] next_row;
    logic [3:0] next_col;
    logic [7:0] pos_distance;
    logic       at_goal;
  } plan_t;

  typedef struct packed {
    request_t req;
    logic     has_exp;
    plan_t    exp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  request_t req_q;
  plan_t plan_d;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  maze_flood_fill_planner dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(req_q.kind), .cell_row_i(req_q.cell_row), .cell_col_i(req_q.cell_col),
    .wall_side_i(req_q.wall_side), .pos_row_i(req_q.pos_row),
    .pos_col_i(req_q.pos_col), .heading_i(req_q.heading),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .move_o(plan_d.move), .next_row_o(plan_d.next_row), .next_col_o(plan_d.next_col),
    .pos_distance_o(plan_d.pos_distance), .at_goal_o(plan_d.at_goal),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [3:0] walls [256];
  logic [7:0] dmap [256];
  logic [3:0] goal_r, goal_c;
  plan_t due_plan [1024];
  plan_t due_exp [1024];
  logic due_fix [1024];
  int due_wr = 0, due_rd = 0;
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic nb_cell(int r, int c, int s, output int nr, output int nc);
    nr = r + (s == SIDE_S) - (s == SIDE_N);
    nc = c + (s == SIDE_E) - (s == SIDE_W);
    return nr >= 0 && nc >= 0 && nr < 16 && nc < 16;
  endfunction

  function automatic int side_at(logic [3:0] w, int k);
    int open_ord [4] = '{SIDE_W, SIDE_E, SIDE_S, SIDE_N};
    int wall_ord [4] = '{SIDE_N, SIDE_S, SIDE_E, SIDE_W};
    return (w == 0) ? open_ord[k] : wall_ord[k];
  endfunction

  function automatic void wall_or(int r, int c, int s);
    int nr, nc;
    walls[r*16+c][s] = 1'b1;
    if (nb_cell(r, c, s, nr, nc)) walls[nr*16+nc][(s+2)%4] = 1'b1;
  endfunction

  function automatic void maze_reset();
    for (int i = 0; i < 256; i++) walls[i] = wall_reset(i[7:4], i[3:0]);
    goal_r = 7;
    goal_c = 7;
  endfunction

  function automatic void flood_distances();
    int fifo [256];
    int qhd, qtl, cur, nr, nc, s, d;
    for (int i = 0; i < 256; i++) dmap[i] = 8'd255;
    dmap[{goal_r, goal_c}] = 0;
    fifo[0] = {goal_r, goal_c};
    qhd = 0;
    qtl = 1;
    while (qhd < qtl) begin
      cur = fifo[qhd];
      d = (dmap[cur] == 255) ? 255 : dmap[cur] + 1;
      for (int k = 0; k < 4; k++) begin
        s = side_at(walls[cur], k);
        if (!walls[cur][s] && nb_cell(cur / 16, cur % 16, s, nr, nc))
          if (dmap[nr*16+nc] == 255 && qtl < 256) begin
            dmap[nr*16+nc] = 8'(d);
            fifo[qtl] = nr*16+nc;
            qtl++;
          end
      end
      qhd++;
    end
  endfunction

  function automatic plan_t plan_move(request_t q);
    plan_t p;
    int r, c, br, bc, bd, nr, nc, s, dir;
    r = q.pos_row;
    c = q.pos_col;
    flood_distances();
    br = r;
    bc = c;
    bd = dmap[r*16+c];
    for (int k = 0; k < 4; k++) begin
      s = side_at(walls[r*16+c], k);
      if (!walls[r*16+c][s] && nb_cell(r, c, s, nr, nc) && dmap[nr*16+nc] < bd) begin
        bd = dmap[nr*16+nc];
        br = nr;
        bc = nc;
      end
    end
    p.move = MV_IDLE;
    if (br != r || bc != c) begin
      dir = (bc < c) ? SIDE_W : (bc > c) ? SIDE_E : (br < r) ? SIDE_N : SIDE_S;
      if (dir == q.heading) p.move = MV_STRAIGHT;
      else if (dir == (q.heading + 1) % 4) p.move = MV_RIGHT;
      else if (dir == (q.heading + 3) % 4) p.move = MV_LEFT;
      else p.move = MV_AROUND;
    end
    p.next_row = 4'(br);
    p.next_col = 4'(bc);
    p.pos_distance = dmap[r*16+c];
    p.at_goal = (q.pos_row == goal_r && q.pos_col == goal_c);
    return p;
  endfunction

  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_GOAL_ROW) goal_r = val[3:0];
    else goal_c = val[3:0];
  endtask

  task automatic send(request_t q, logic has_exp = 0, plan_t exp = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    req_q <= q;
    in_valid <= 1;
    if (q.kind == KIND_REPLAN) begin
      due_plan[due_wr] = plan_move(q);
      due_fix[due_wr] = has_exp;
      due_exp[due_wr] = exp;
      due_wr++;
    end else wall_or(q.cell_row, q.cell_col, q.wall_side);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (due_rd != due_wr) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic request_t rand_req(int replan_pct);
    request_t q;
    q = request_t'({$urandom, $urandom});
    q.kind = ($urandom_range(99) < replan_pct) ? KIND_REPLAN : KIND_WALL;
    return q;
  endfunction

  always @(posedge clk) begin
    plan_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (due_rd == due_wr) begin
        errors++;
        $display("%0t unexpected result exp none got %h", $time, plan_d);
      end else begin
        e = due_plan[due_rd];
        if (due_fix[due_rd] && due_exp[due_rd] !== plan_d) begin
          errors++;
          $display("%0t table mismatch exp %h got %h", $time, due_exp[due_rd], plan_d);
        end
        due_rd++;
        if (e !== plan_d) begin
          errors++;
          $display("%0t mismatch exp %h got %h", $time, e, plan_d);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_idle);
  end

  row_t dir_tab [] = '{
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd7, 4'd7, 2'd0}, 1'b1, '{MV_IDLE, 4'd7, 4'd7, 8'd0, 1'b1}},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd0, 4'd0, 2'd0}, 1'b1, '{MV_AROUND, 4'd1, 4'd0, 8'd14, 1'b0}},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd15, 4'd15, 2'd3}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd15, 4'd0, 2'd1}, 1'b0, '0},
    '{'{KIND_WALL, 4'd7, 4'd7, 2'd0, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_WALL, 4'd7, 4'd7, 2'd1, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_WALL, 4'd7, 4'd7, 2'd2, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_WALL, 4'd0, 4'd0, 2'd3, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_WALL, 4'd15, 4'd15, 2'd1, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd7, 4'd8, 2'd0}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd8, 4'd7, 2'd1}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd6, 4'd7, 2'd2}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd7, 4'd6, 2'd3}, 1'b0, '0},
    '{'{KIND_WALL, 4'd7, 4'd7, 2'd3, 4'd0, 4'd0, 2'd0}, 1'b0, '0},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd3, 4'd3, 2'd0}, 1'b1, '{MV_IDLE, 4'd3, 4'd3, 8'd255, 1'b0}},
    '{'{KIND_REPLAN, 4'd0, 4'd0, 2'd0, 4'd7, 4'd7, 2'd2}, 1'b1, '{MV_IDLE, 4'd7, 4'd7, 8'd0, 1'b1}}
  };

  task automatic random_phase(int n, int sidle, int ridle);
    send_idle = sidle;
    recv_idle = ridle;
    for (int i = 0; i < n; i++) send(rand_req(25));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    req_q = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    maze_reset();
    repeat (12) @(negedge clk);
    rst_n = 1;
    foreach (dir_tab[i]) send(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);
    drain();
    reg_write(REG_GOAL_ROW, 0);
    reg_write(REG_GOAL_COL, 15);
    random_phase(130, 26, 79);
    drain();
    reg_write(REG_GOAL_ROW, 15);
    reg_write(REG_GOAL_COL, 0);
    hold_off = 8000;
    random_phase(130, 79, 26);
    drain();
    reg_write(REG_GOAL_ROW, 32'hFFFF_FFF5);
    reg_write(REG_GOAL_COL, 9);
    random_phase(130, 0, 0);
    drain();
    reg_write(REG_GOAL_ROW, 2);
    reg_write(REG_GOAL_COL, 13);
    random_phase(130, 0, 0);
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mffp_pkg.sv
rtl/core/mffp_map.sv
rtl/core/mffp_queue.sv
rtl/core/maze_flood_fill_planner.sv
bench/tb_maze_flood_fill_planner.sv
